// ----- rtl/pcr_pkg.sv -----
// ---------------------------------------------------------------------------
// Particle contact resolver package
// Field widths, stream offsets and fixed-point constants shared by the block.
// ---------------------------------------------------------------------------
package pcr_pkg;

	localparam int VEC_BITS  = 63;   // packed vector field width
	localparam int IMW       = 24;   // inverse mass, unsigned Q8.16
	localparam int TOTW      = 25;   // sum of two inverse masses
	localparam int EW        = 16;   // elasticity, Q1.15
	localparam int PENW      = 24;   // penetration, signed Q8.16
	localparam int PEN_MAGW  = 23;   // penetration after clamping at zero
	localparam int EPW       = 32;   // elasticity product
	localparam int FACW      = 17;   // 1.0 + restitution, Q2.15
	localparam logic [EW-1:0] ONE_Q15 = 16'd32768;

	// Input transfer layout.
	localparam int IN_FV  = 0;
	localparam int IN_SV  = 63;
	localparam int IN_FP  = 126;
	localparam int IN_SP  = 189;
	localparam int IN_CN  = 252;
	localparam int IN_IM1 = 315;
	localparam int IN_IM2 = 339;
	localparam int IN_E1  = 363;
	localparam int IN_E2  = 379;
	localparam int IN_PEN = 395;
	localparam int IN_BITS = 424;

	// Output transfer layout.
	localparam int OUT_FV   = 0;
	localparam int OUT_SV   = 63;
	localparam int OUT_FP   = 126;
	localparam int OUT_SP   = 189;
	localparam int OUT_IMP  = 252;
	localparam int OUT_PUSH = 253;
	localparam int OUT_SAT  = 254;
	localparam int OUT_BITS = 256;

endpackage

// ----- rtl/pcr_div.sv -----
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; the dividend is known to give a quotient that
// fits in QW bits, so the top part of the dividend starts as the remainder.
// ---------------------------------------------------------------------------
module pcr_div #(
	parameter int QW = 25
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [QW+pcr_pkg::IMW-1:0]    num,
	input  logic [pcr_pkg::TOTW-1:0]      den,
	output logic [QW-1:0]                 quo,
	output logic                          rem_nz
);

	localparam int DW = pcr_pkg::TOTW;

	logic [DW-1:0] rem_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic [QW-1:0] low_s [0:QW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(num[QW+pcr_pkg::IMW-1:QW]);
			den_s[0] <= den;
			quo_s[0] <= '0;
			low_s[0] <= num[QW-1:0];
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		always_comb begin
			trial = {rem_s[k-1], low_s[k-1][QW-1]};
			diff  = trial - {1'b0, den_s[k-1]};
			ge    = trial >= {1'b0, den_s[k-1]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				den_s[k] <= den_s[k-1];
				quo_s[k] <= {quo_s[k-1][QW-2:0], ge};
			end
		end

		if (k < QW) begin : g_low
			always_ff @(posedge clk) begin
				if (en) begin
					low_s[k] <= {low_s[k-1][QW-2:0], 1'b0};
				end
			end
		end
	end

	assign quo    = quo_s[QW];
	assign rem_nz = |rem_s[QW];

endmodule

// ----- rtl/particle_contact_resolver_top.sv -----
// Throughput: one contact per cycle while the output is not stalled.
// The depth is set by the two pipelined dividers, one quotient bit per stage.
// A stall at the output freezes the whole pipeline; nothing is lost.
// Reset clears all valid bits; data registers are not reset.
// ---------------------------------------------------------------------------
// Particle contact resolver
// Impulse and interpenetration correction for one contact per transfer.
// ---------------------------------------------------------------------------
module particle_contact_resolver_top #(
	parameter int COMPONENT_WIDTH = 21
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// fields from bit 0: first_velocity, second_velocity, first_position,
	// second_position, contact_normal, first_inverse_mass,
	// second_inverse_mass, first_elasticity, second_elasticity,
	// penetration_depth, zero fill
	input  logic [pcr_pkg::IN_BITS-1:0]    s_tdata,
	// bit 0: second_present
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// fields from bit 0: new_first_velocity, new_second_velocity,
	// new_first_position, new_second_position, impulse_applied,
	// push_applied, saturated, zero fill
	output logic [pcr_pkg::OUT_BITS-1:0]   m_tdata
);

	localparam int W    = COMPONENT_WIDTH;
	localparam int VW   = 3 * W;
	localparam int DQW  = (W + 4 > pcr_pkg::PEN_MAGW) ? W + 4 : pcr_pkg::PEN_MAGW;
	localparam int NW   = DQW + pcr_pkg::IMW;
	localparam int PRW  = 2 * W + 1;
	localparam int SEPW = 2 * W + 3;
	localparam int NSW  = 2 * W + 1;
	localparam int BIGW = NSW + pcr_pkg::FACW;
	localparam int PW   = W + DQW + 1;
	localparam int SUMW = PW + 1;
	localparam logic signed [SUMW-1:0] HI = (SUMW'(1) <<< (W - 1)) - SUMW'(1);
	localparam logic signed [SUMW-1:0] LO = -HI - SUMW'(1);

	typedef struct packed {
		logic [VW-1:0] v1;
		logic [VW-1:0] v2;
		logic [VW-1:0] p1;
		logic [VW-1:0] p2;
		logic [VW-1:0] nrm;
		logic          present;
	} vec_t;

	typedef struct packed {
		vec_t           vec;
		logic [DQW-1:0] dv;
		logic [DQW-1:0] pen;
		logic           imp;
		logic           push;
	} ctx_t;

	logic en;

	// Valid bits.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_d [0:DQW];
	logic vld_s8, vld_s9, vld_s10;

	// Stage 1: unpacked and gated input fields.
	vec_t                          vec_s1;
	logic [pcr_pkg::IMW-1:0]       im1_s1;
	logic [pcr_pkg::TOTW-1:0]      total_s1;
	logic [pcr_pkg::EW-1:0]        e1_s1, e2_s1;
	logic [pcr_pkg::PEN_MAGW-1:0]  pen_s1;
	vec_t                          vec_in;
	logic [pcr_pkg::IMW-1:0]       im1_in, im2_in;
	logic [pcr_pkg::EW-1:0]        e1_in, e2_in;
	logic [pcr_pkg::PENW-1:0]      pen_in;

	// Stage 2.
	vec_t                          vec_s2;
	logic signed [W:0]             d_s2 [3];
	logic [pcr_pkg::EPW-1:0]       ep_s2;
	logic [pcr_pkg::IMW-1:0]       im1_s2;
	logic [pcr_pkg::TOTW-1:0]      total_s2;
	logic [pcr_pkg::PEN_MAGW-1:0]  pen_s2;

	// Stage 3.
	vec_t                          vec_s3;
	logic signed [PRW-1:0]         prod_s3 [3];
	logic [pcr_pkg::FACW-1:0]      fac_s3;
	logic [pcr_pkg::IMW-1:0]       im1_s3;
	logic [pcr_pkg::TOTW-1:0]      total_s3;
	logic [pcr_pkg::PEN_MAGW-1:0]  pen_s3;

	// Stage 4.
	vec_t                          vec_s4;
	logic signed [SEPW-1:0]        sep_s4;
	logic [pcr_pkg::FACW-1:0]      fac_s4;
	logic [pcr_pkg::IMW-1:0]       im1_s4;
	logic [pcr_pkg::TOTW-1:0]      total_s4;
	logic [pcr_pkg::PEN_MAGW-1:0]  pen_s4;

	// Stage 5.
	vec_t                          vec_s5;
	logic [NSW-1:0]                nsep_s5;
	logic [pcr_pkg::FACW-1:0]      fac_s5;
	logic                          imp_s5, push_s5;
	logic [pcr_pkg::IMW-1:0]       im1_s5;
	logic [pcr_pkg::TOTW-1:0]      total_s5;
	logic [pcr_pkg::PEN_MAGW-1:0]  pen_s5;

	// Stage 6.
	vec_t                          vec_s6;
	logic [BIGW-1:0]               big_s6;
	logic                          imp_s6, push_s6;
	logic [pcr_pkg::IMW-1:0]       im1_s6;
	logic [pcr_pkg::TOTW-1:0]      total_s6;
	logic [pcr_pkg::PEN_MAGW-1:0]  pen_s6;

	// Stage 7: dividends for the two dividers.
	ctx_t                          ctx_s7;
	logic [NW-1:0]                 nv_s7, np_s7;
	logic [pcr_pkg::TOTW-1:0]      total_s7;
	logic [DQW-1:0]                dv_w;

	// Context travelling beside the dividers.
	ctx_t                          ctx_d [0:DQW];
	logic [DQW-1:0]                quo_v, quo_p;
	logic                          nz_v, nz_p;

	// Stage 8: per-particle scale factors.
	vec_t                          vec_s8;
	logic [DQW-1:0]                sv1_s8, sv2_s8, sp1_s8, sp2_s8;
	logic                          imp_s8, push_s8;

	// Stage 9: normal times scale.
	vec_t                          vec_s9;
	logic signed [PW-1:0]          pv1_s9 [3];
	logic signed [PW-1:0]          pv2_s9 [3];
	logic signed [PW-1:0]          pp1_s9 [3];
	logic signed [PW-1:0]          pp2_s9 [3];
	logic                          imp_s9, push_s9;

	// Stage 10: output register.
	logic [VW-1:0]                 fv_s10, sv_s10, fp_s10, sp_s10;
	logic                          imp_s10, push_s10, sat_s10;
	logic [VW-1:0]                 fv_w, sv_w, fp_w, sp_w;
	logic                          sat1_w, sat2_w;

	assign en       = !vld_s10 || m_tready;
	assign s_tready = en;

	always_comb begin
		vec_in.present = s_tuser[0];
		vec_in.v1      = s_tdata[pcr_pkg::IN_FV +: VW];
		vec_in.p1      = s_tdata[pcr_pkg::IN_FP +: VW];
		vec_in.nrm     = s_tdata[pcr_pkg::IN_CN +: VW];
		vec_in.v2      = s_tuser[0] ? s_tdata[pcr_pkg::IN_SV +: VW] : '0;
		vec_in.p2      = s_tuser[0] ? s_tdata[pcr_pkg::IN_SP +: VW] : '0;
		im1_in         = s_tdata[pcr_pkg::IN_IM1 +: pcr_pkg::IMW];
		im2_in         = s_tuser[0] ? s_tdata[pcr_pkg::IN_IM2 +: pcr_pkg::IMW] : '0;
		e1_in          = s_tdata[pcr_pkg::IN_E1 +: pcr_pkg::EW];
		e2_in          = s_tuser[0] ? s_tdata[pcr_pkg::IN_E2 +: pcr_pkg::EW]
		                            : pcr_pkg::ONE_Q15;
		pen_in         = s_tdata[pcr_pkg::IN_PEN +: pcr_pkg::PENW];
	end

	assign dv_w = DQW'(big_s6[W+13 +: W+4]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			for (int k = 0; k <= DQW; k++) vld_d[k] <= 1'b0;
		end else if (en) begin
			vld_s1   <= s_tvalid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_s5   <= vld_s4;
			vld_s6   <= vld_s5;
			vld_s7   <= vld_s6;
			vld_d[0] <= vld_s7;
			for (int k = 1; k <= DQW; k++) vld_d[k] <= vld_d[k-1];
			vld_s8   <= vld_d[DQW];
			vld_s9   <= vld_s8;
			vld_s10  <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: clamp elasticities and penetration, total inverse mass.
			vec_s1   <= vec_in;
			im1_s1   <= im1_in;
			total_s1 <= pcr_pkg::TOTW'(im1_in) + pcr_pkg::TOTW'(im2_in);
			e1_s1    <= (e1_in > pcr_pkg::ONE_Q15) ? pcr_pkg::ONE_Q15 : e1_in;
			e2_s1    <= (e2_in > pcr_pkg::ONE_Q15) ? pcr_pkg::ONE_Q15 : e2_in;
			pen_s1   <= pen_in[pcr_pkg::PENW-1] ? '0 : pen_in[pcr_pkg::PEN_MAGW-1:0];

			// Stage 2: relative velocity, elasticity product.
			vec_s2   <= vec_s1;
			for (int i = 0; i < 3; i++) begin
				d_s2[i] <= (W+1)'($signed(vec_s1.v1[i*W +: W]))
				         - (W+1)'($signed(vec_s1.v2[i*W +: W]));
			end
			ep_s2    <= pcr_pkg::EPW'(e1_s1) * pcr_pkg::EPW'(e2_s1);
			im1_s2   <= im1_s1;
			total_s2 <= total_s1;
			pen_s2   <= pen_s1;

			// Stage 3: per-axis products of the dot product.
			vec_s3   <= vec_s2;
			for (int i = 0; i < 3; i++) begin
				prod_s3[i] <= PRW'(d_s2[i]) * PRW'($signed(vec_s2.nrm[i*W +: W]));
			end
			fac_s3   <= pcr_pkg::FACW'(pcr_pkg::ONE_Q15) + pcr_pkg::FACW'(ep_s2[30:15]);
			im1_s3   <= im1_s2;
			total_s3 <= total_s2;
			pen_s3   <= pen_s2;

			// Stage 4: separation velocity.
			vec_s4   <= vec_s3;
			sep_s4   <= SEPW'(prod_s3[0]) + SEPW'(prod_s3[1]) + SEPW'(prod_s3[2]);
			fac_s4   <= fac_s3;
			im1_s4   <= im1_s3;
			total_s4 <= total_s3;
			pen_s4   <= pen_s3;

			// Stage 5: closing speed and decisions.
			vec_s5   <= vec_s4;
			nsep_s5  <= (sep_s4 > 0) ? '0 : NSW'(-sep_s4);
			imp_s5   <= (sep_s4 <= 0) && (total_s4 != '0);
			push_s5  <= (pen_s4 != '0) && (total_s4 != '0);
			fac_s5   <= fac_s4;
			im1_s5   <= im1_s4;
			total_s5 <= total_s4;
			pen_s5   <= pen_s4;

			// Stage 6: closing speed times (1 + restitution).
			vec_s6   <= vec_s5;
			big_s6   <= BIGW'(nsep_s5) * BIGW'(fac_s5);
			imp_s6   <= imp_s5;
			push_s6  <= push_s5;
			im1_s6   <= im1_s5;
			total_s6 <= total_s5;
			pen_s6   <= pen_s5;

			// Stage 7: numerators scaled by the first inverse mass.
			ctx_s7.vec  <= vec_s6;
			ctx_s7.dv   <= dv_w;
			ctx_s7.pen  <= DQW'(pen_s6);
			ctx_s7.imp  <= imp_s6;
			ctx_s7.push <= push_s6;
			nv_s7       <= NW'(dv_w) * NW'(im1_s6);
			np_s7       <= NW'(pen_s6) * NW'(im1_s6);
			total_s7    <= total_s6;

			ctx_d[0] <= ctx_s7;
			for (int k = 1; k <= DQW; k++) ctx_d[k] <= ctx_d[k-1];

			// Stage 8: the second share is the whole minus the first, rounded down.
			vec_s8  <= ctx_d[DQW].vec;
			imp_s8  <= ctx_d[DQW].imp;
			push_s8 <= ctx_d[DQW].push;
			sv1_s8  <= ctx_d[DQW].imp ? quo_v : '0;
			sv2_s8  <= ctx_d[DQW].imp ? ctx_d[DQW].dv - quo_v - DQW'(nz_v) : '0;
			sp1_s8  <= ctx_d[DQW].push ? quo_p : '0;
			sp2_s8  <= ctx_d[DQW].push ? ctx_d[DQW].pen - quo_p - DQW'(nz_p) : '0;

			// Stage 9: normal components times the shares.
			vec_s9  <= vec_s8;
			imp_s9  <= imp_s8;
			push_s9 <= push_s8;
			for (int i = 0; i < 3; i++) begin
				pv1_s9[i] <= PW'($signed(vec_s8.nrm[i*W +: W])) * PW'($signed({1'b0, sv1_s8}));
				pv2_s9[i] <= PW'($signed(vec_s8.nrm[i*W +: W])) * PW'($signed({1'b0, sv2_s8}));
				pp1_s9[i] <= PW'($signed(vec_s8.nrm[i*W +: W])) * PW'($signed({1'b0, sp1_s8}));
				pp2_s9[i] <= PW'($signed(vec_s8.nrm[i*W +: W])) * PW'($signed({1'b0, sp2_s8}));
			end

			// Stage 10: apply, saturate, pack.
			fv_s10   <= fv_w;
			fp_s10   <= fp_w;
			sv_s10   <= vec_s9.present ? sv_w : '0;
			sp_s10   <= vec_s9.present ? sp_w : '0;
			imp_s10  <= imp_s9;
			push_s10 <= push_s9;
			sat_s10  <= sat1_w || (vec_s9.present && sat2_w);
		end
	end

	pcr_div #(.QW(DQW)) u_div_vel (
		.clk    (clk),
		.en     (en),
		.num    (nv_s7),
		.den    (total_s7),
		.quo    (quo_v),
		.rem_nz (nz_v)
	);

	pcr_div #(.QW(DQW)) u_div_pos (
		.clk    (clk),
		.en     (en),
		.num    (np_s7),
		.den    (total_s7),
		.quo    (quo_p),
		.rem_nz (nz_p)
	);

	// Shifts are arithmetic, so every reduction rounds toward minus infinity.
	always_comb begin
		logic signed [SUMW-1:0] s_fv, s_sv, s_fp, s_sp;
		sat1_w = 1'b0;
		sat2_w = 1'b0;
		fv_w   = '0;
		sv_w   = '0;
		fp_w   = '0;
		sp_w   = '0;
		for (int i = 0; i < 3; i++) begin
			s_fv = SUMW'($signed(vec_s9.v1[i*W +: W])) + SUMW'(pv1_s9[i] >>> (W - 2));
			s_sv = SUMW'($signed(vec_s9.v2[i*W +: W])) - SUMW'(pv2_s9[i] >>> (W - 2));
			s_fp = SUMW'($signed(vec_s9.p1[i*W +: W])) + SUMW'(pp1_s9[i] >>> (W + 3));
			s_sp = SUMW'($signed(vec_s9.p2[i*W +: W])) - SUMW'(pp2_s9[i] >>> (W + 3));
			if (s_fv > HI) begin s_fv = HI; sat1_w = 1'b1; end
			if (s_fv < LO) begin s_fv = LO; sat1_w = 1'b1; end
			if (s_fp > HI) begin s_fp = HI; sat1_w = 1'b1; end
			if (s_fp < LO) begin s_fp = LO; sat1_w = 1'b1; end
			if (s_sv > HI) begin s_sv = HI; sat2_w = 1'b1; end
			if (s_sv < LO) begin s_sv = LO; sat2_w = 1'b1; end
			if (s_sp > HI) begin s_sp = HI; sat2_w = 1'b1; end
			if (s_sp < LO) begin s_sp = LO; sat2_w = 1'b1; end
			fv_w[i*W +: W] = s_fv[W-1:0];
			sv_w[i*W +: W] = s_sv[W-1:0];
			fp_w[i*W +: W] = s_fp[W-1:0];
			sp_w[i*W +: W] = s_sp[W-1:0];
		end
	end

	assign m_tvalid = vld_s10;

	always_comb begin
		m_tdata = '0;
		m_tdata[pcr_pkg::OUT_FV +: VW] = fv_s10;
		m_tdata[pcr_pkg::OUT_SV +: VW] = sv_s10;
		m_tdata[pcr_pkg::OUT_FP +: VW] = fp_s10;
		m_tdata[pcr_pkg::OUT_SP +: VW] = sp_s10;
		m_tdata[pcr_pkg::OUT_IMP]      = imp_s10;
		m_tdata[pcr_pkg::OUT_PUSH]     = push_s10;
		m_tdata[pcr_pkg::OUT_SAT]      = sat_s10;
	end

endmodule
